FILE: hdl/pcbd_pkg.sv
package pcbd_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_DATA  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Symbols with a first byte above this carry a second byte
    localparam logic [7:0] SYM_SPLIT = 8'd127;

    // Accumulator state passed down the cell chain
    typedef struct packed {
        logic [63:0] bits;
        logic [6:0]  len;
    } acc_t;

    // Match result passed down the cell chain
    typedef struct packed {
        logic        hit;
        logic [15:0] symbol;
    } hit_t;

endpackage

FILE: hdl/prefix_code_bitstream_decoder.sv
// Prefix-code stream decoder. Mode 1 loads table entries into a chain of
// MAX_ENTRIES cells; mode 0 clears the table; mode 2 decodes a byte MSB first.
// A data byte is accepted, then its valid stream bits (up to 8) are shifted in
// one at a time, then a closing state ends the byte; each bit is compared
// against all entries in the cell chain in the cycle it is shifted in. The
// newest result of a byte is held back until the byte ends so that its last
// flag is known; a bit that produces a result while one is held and the output
// register is still full waits, as does the closing state.
module prefix_code_bitstream_decoder #(
    parameter int MAX_ENTRIES  = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_entry_code,
    input  logic [5:0]  s_entry_length,
    input  logic [15:0] s_entry_symbol,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [3:0]  s_valid_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_first_byte,
    output logic [7:0]  m_second_byte,
    output logic        m_two_bytes,
    output logic        m_status,
    output logic        m_last
);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BITS  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg;
    pcbd_pkg::acc_t acc_reg, acc_cand;
    logic [7:0]     byte_reg;
    logic [3:0]     left_reg;
    logic           fin_reg;
    logic           accept, emit, err;
    logic           out_free, step, push_mid, push_end;
    logic           pend_valid_reg;
    logic [7:0]     pend_first_reg, pend_second_reg;
    logic           pend_two_reg, pend_status_reg;
    logic [7:0]     new_first, new_second;
    logic           new_two;
    pcbd_pkg::hit_t chain [MAX_ENTRIES+1];

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Candidate accumulator after shifting in the next bit
    always_comb begin
        acc_cand.bits = {acc_reg.bits[62:0], byte_reg[7]};
        acc_cand.len  = acc_reg.len + 7'd1;
    end

    // Cell chain
    assign chain[0] = '0;
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        pcbd_cell u_cell (
            .aclk    (aclk),
            .load_en (accept && (s_mode == pcbd_pkg::MODE_LOAD)
                      && (count_reg == CW'(i))),
            .ld_code (s_entry_code),
            .ld_len  (s_entry_length),
            .ld_sym  (s_entry_symbol),
            .active  (count_reg > CW'(i)),
            .acc     (acc_cand),
            .hit_in  (chain[i]),
            .hit_out (chain[i+1])
        );
    end

    assign err  = !chain[MAX_ENTRIES].hit && (acc_cand.len >= 7'(MAX_CODE_LEN));
    assign emit = chain[MAX_ENTRIES].hit || err;

    // Result built from the current bit
    always_comb begin
        new_first  = err ? 8'd0 : chain[MAX_ENTRIES].symbol[15:8];
        new_two    = !err && (chain[MAX_ENTRIES].symbol[15:8] > pcbd_pkg::SYM_SPLIT);
        new_second = new_two ? chain[MAX_ENTRIES].symbol[7:0] : 8'd0;
    end

    // A bit advances unless it needs the output register while that is full
    assign out_free = !m_valid || m_ready;
    assign step     = (state_reg == ST_BITS) && (left_reg != 4'd0)
                      && (!emit || !pend_valid_reg || out_free);
    assign push_mid = step && emit && pend_valid_reg;
    assign push_end = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_mode == pcbd_pkg::MODE_DATA) state_next = ST_BITS;
            end
            ST_BITS: begin
                if (left_reg == 4'd0 || (step && left_reg == 4'd1))
                    state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            acc_reg        <= '0;
            m_valid        <= 1'b0;
            left_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (pcbd_pkg::mode_t'(s_mode))
                            pcbd_pkg::MODE_CLEAR: begin
                                count_reg <= '0;
                                acc_reg   <= '0;
                            end
                            pcbd_pkg::MODE_LOAD: begin
                                if (count_reg < CW'(MAX_ENTRIES))
                                    count_reg <= count_reg + CW'(1);
                            end
                            pcbd_pkg::MODE_DATA: begin
                                byte_reg <= s_data_byte;
                                fin_reg  <= s_last_byte;
                                left_reg <= !s_last_byte ? 4'd8 :
                                    (s_valid_bits > 4'd8 ? 4'd8 : s_valid_bits);
                            end
                            default: ;
                        endcase
                    end
                end
                ST_BITS: begin
                    if (left_reg == 4'd0) begin
                        if (fin_reg) acc_reg <= '0;
                    end else if (step) begin
                        byte_reg <= {byte_reg[6:0], 1'b0};
                        left_reg <= left_reg - 4'd1;
                        if (emit || (left_reg == 4'd1 && fin_reg)) acc_reg <= '0;
                        else acc_reg <= acc_cand;
                    end
                end
                default: ;
            endcase

            // Held result: newest result of the byte
            if (step && emit) begin
                pend_valid_reg  <= 1'b1;
                pend_first_reg  <= new_first;
                pend_second_reg <= new_second;
                pend_two_reg    <= new_two;
                pend_status_reg <= err;
            end else if (push_end) begin
                pend_valid_reg <= 1'b0;
            end

            // Output register; the held result is final when the byte ends
            if (push_mid || push_end) begin
                m_valid       <= 1'b1;
                m_first_byte  <= pend_first_reg;
                m_second_byte <= pend_second_reg;
                m_two_bytes   <= pend_two_reg;
                m_status      <= pend_status_reg;
                m_last        <= push_end;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BITS |-> !s_ready) else $error("input taken mid-byte");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES)) else $error("entry count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg) else $error("result left behind");
endmodule

FILE: hdl/pcbd_cell.sv
// One table entry: holds its code and compares it with the accumulator.
// The hit from lower-indexed cells has priority and passes on unchanged.
module pcbd_cell (
    input  logic           aclk,
    input  logic           load_en,
    input  logic [31:0]    ld_code,
    input  logic [5:0]     ld_len,
    input  logic [15:0]    ld_sym,
    input  logic           active,
    input  pcbd_pkg::acc_t acc,
    input  pcbd_pkg::hit_t hit_in,
    output pcbd_pkg::hit_t hit_out
);
    logic [31:0] code_reg;
    logic [5:0]  len_reg;
    logic [15:0] sym_reg;
    logic [63:0] mask;
    logic        match;

    // Entry storage
    always_ff @(posedge aclk) begin
        if (load_en) begin
            code_reg <= ld_code;
            len_reg  <= ld_len;
            sym_reg  <= ld_sym;
        end
    end

    // Exact code and length compare
    always_comb begin
        mask  = (64'd1 << len_reg) - 64'd1;
        match = active && (len_reg != 6'd0) && ({1'b0, len_reg} == acc.len)
                && (({32'd0, code_reg} & mask) == acc.bits);
        if (hit_in.hit) begin
            hit_out = hit_in;
        end else begin
            hit_out.hit    = match;
            hit_out.symbol = sym_reg;
        end
    end
endmodule

FILE: verif/prefix_code_bitstream_decoder_tb.sv
module prefix_code_bitstream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 32;
    localparam int CODE_LEN_MAX = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       two_bytes;
        logic       status;
        logic       last;
    } symbol_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = pcbd_pkg::MODE_NONE;
    logic [31:0] s_entry_code = '0;
    logic [5:0]  s_entry_length = '0;
    logic [15:0] s_entry_symbol = '0;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic [3:0]  s_valid_bits = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_first_byte;
    logic [7:0]  m_second_byte;
    logic        m_two_bytes;
    logic        m_status;
    logic        m_last;

    // Model state of the decoder
    logic [31:0] code_tbl [TABLE_DEPTH];
    logic [5:0]  len_tbl [TABLE_DEPTH];
    logic [15:0] sym_tbl [TABLE_DEPTH];
    int          n_entries;
    logic [63:0] shift_bits;
    int          shift_len;

    symbol_out_t expected_symbols [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;

    always #2 aclk = ~aclk;

    prefix_code_bitstream_decoder #(
        .MAX_ENTRIES  (TABLE_DEPTH),
        .MAX_CODE_LEN (CODE_LEN_MAX)
    ) i_dut (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL prefix_code_bitstream_decoder");
            $finish;
        end
    end

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Predict the results that one request produces
    task automatic predict_request(input logic [1:0] mode, input logic [31:0] code,
                                   input logic [5:0] len, input logic [15:0] sym,
                                   input logic [7:0] data, input logic fin,
                                   input logic [3:0] vbits);
        symbol_out_t r;
        int nbits;
        int hit;
        int first_new;
        first_new = expected_symbols.size();
        case (mode)
            pcbd_pkg::MODE_CLEAR: begin
                n_entries = 0;
                shift_bits = '0;
                shift_len = 0;
            end
            pcbd_pkg::MODE_LOAD: begin
                if (n_entries < TABLE_DEPTH) begin
                    code_tbl[n_entries] = code;
                    len_tbl[n_entries] = len;
                    sym_tbl[n_entries] = sym;
                    n_entries++;
                end
            end
            pcbd_pkg::MODE_DATA: begin
                nbits = fin ? ((vbits > 8) ? 8 : int'(vbits)) : 8;
                for (int b = 0; b < nbits; b++) begin
                    shift_bits = {shift_bits[62:0], data[7-b]};
                    shift_len++;
                    hit = -1;
                    for (int i = 0; i < n_entries; i++) begin
                        if (len_tbl[i] != 0 && int'(len_tbl[i]) == shift_len &&
                            (64'(code_tbl[i]) & ((64'd1 << len_tbl[i]) - 1))
                                == shift_bits) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit >= 0) begin
                        r = '0;
                        r.first_byte = sym_tbl[hit][15:8];
                        r.two_bytes = sym_tbl[hit][15:8] > pcbd_pkg::SYM_SPLIT;
                        r.second_byte = r.two_bytes ? sym_tbl[hit][7:0] : 8'd0;
                        expected_symbols.insert(expected_symbols.size(), r);
                        shift_bits = '0;
                        shift_len = 0;
                    end else if (shift_len >= CODE_LEN_MAX) begin
                        r = '0;
                        r.status = 1'b1;
                        expected_symbols.insert(expected_symbols.size(), r);
                        shift_bits = '0;
                        shift_len = 0;
                    end
                end
                if (fin) begin
                    shift_bits = '0;
                    shift_len = 0;
                end
            end
            default: ;
        endcase
        if (expected_symbols.size() > first_new)
            expected_symbols[$].last = 1'b1;
    endtask

    // Send one request and wait for it to be taken
    task automatic send_request(input logic [1:0] mode, input logic [31:0] code,
                                input logic [5:0] len, input logic [15:0] sym,
                                input logic [7:0] data, input logic fin,
                                input logic [3:0] vbits);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_entry_code <= code;
        s_entry_length <= len;
        s_entry_symbol <= sym;
        s_data_byte <= data;
        s_last_byte <= fin;
        s_valid_bits <= vbits;
        predict_request(mode, code, len, sym, data, fin, vbits);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_entry(input logic [31:0] code, input logic [5:0] len,
                              input logic [15:0] sym);
        send_request(pcbd_pkg::MODE_LOAD, code, len, sym, 8'($urandom), 1'($urandom),
                     4'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data, input logic fin,
                             input logic [3:0] vbits);
        send_request(pcbd_pkg::MODE_DATA, $urandom, 6'($urandom), 16'($urandom), data,
                     fin, vbits);
    endtask

    task automatic clear_table();
        send_request(pcbd_pkg::MODE_CLEAR, $urandom, 6'($urandom), 16'($urandom),
                     8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    // Receiver ready with random stalls and an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 :
                       ($urandom_range(0, 3) != 0);
    end

    // Result checker
    always @(posedge aclk) begin
        symbol_out_t got;
        symbol_out_t exp_sym;
        if (aresetn && m_valid && m_ready) begin
            got = {m_first_byte, m_second_byte, m_two_bytes, m_status, m_last};
            if (expected_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end else begin
                exp_sym = expected_symbols.pop_front();
                if (got !== exp_sym) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected fb=%h sb=%h two=%b st=%b last=%b,",
                                 exp_sym.first_byte, exp_sym.second_byte,
                                 exp_sym.two_bytes, exp_sym.status, exp_sym.last,
                                 " got fb=%h sb=%h two=%b st=%b last=%b",
                                 got.first_byte, got.second_byte, got.two_bytes,
                                 got.status, got.last);
                end
            end
        end
    end

    // A small prefix-free code: 0, 10, 110, 1110, 1111
    task automatic load_basic_code();
        clear_table();
        load_entry(32'hFFFF_FFF0, 6'd1, 16'h4100);
        load_entry(32'h0000_0002, 6'd2, 16'hC3A9);
        load_entry(32'h0000_0006, 6'd3, 16'hFFFF);
        load_entry(32'h0000_000E, 6'd4, 16'h7F55);
        load_entry(32'h0000_000F, 6'd4, 16'h80AA);
    endtask

    task automatic test_directed();
        load_basic_code();
        send_byte(8'h00, 1'b0, 4'd0);
        send_byte(8'hFF, 1'b0, 4'd15);
        send_byte(8'hB6, 1'b0, 4'd3);
        send_byte(8'hEF, 1'b1, 4'd8);
        send_byte(8'hAC, 1'b1, 4'd5);
        send_byte(8'hFF, 1'b1, 4'd0);
        send_byte(8'hE0, 1'b1, 4'd12);
        send_request(pcbd_pkg::MODE_NONE, '1, '1, '1, '1, 1'b1, '1);
        // Duplicate, zero-length and too-long entries
        load_entry(32'h0000_0000, 6'd1, 16'h1234);
        load_entry(32'h0000_0000, 6'd0, 16'h2222);
        load_entry(32'h0000_0000, 6'd33, 16'h3333);
        send_byte(8'h55, 1'b0, 4'd1);
        // No match within the maximum length: errors
        clear_table();
        load_entry(32'hFFFF_FFFF, 6'd63, 16'h1111);
        for (int i = 0; i < 9; i++) send_byte(8'hA5, 1'b0, 4'd7);
        send_byte(8'h3C, 1'b1, 4'd8);
    endtask

    task automatic test_table_full();
        clear_table();
        for (int i = 0; i < TABLE_DEPTH + 4; i++)
            load_entry((i < TABLE_DEPTH) ? 32'h0 : 32'h1, 6'd32,
                       (i < TABLE_DEPTH) ? 16'(i) : 16'hDEAD);
        // All-zero 32-bit code hits entry 0; all-ones hits no entry and reports an error
        for (int i = 0; i < 8; i++) send_byte(8'h00, 1'b0, 4'd0);
        for (int i = 0; i < 4; i++) send_byte(8'hFF, 1'b0, 4'd0);
    endtask

    task automatic test_backpressure();
        load_basic_code();
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 12; i++) send_byte(8'h00, 1'b0, 4'd0);
            end
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
    endtask

    task automatic test_random();
        int len;
        int items;
        items = 0;
        while (items < 170) begin
            // New random table, mostly short codes, occasionally wide
            if ($urandom_range(0, 5) == 0 || items == 0) begin
                clear_table();
                for (int k = $urandom_range(1, 10); k > 0; k--) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(1, 5);
                    load_entry($urandom, 6'(len), 16'($urandom));
                    items++;
                end
            end
            case ($urandom_range(0, 19))
                0: send_request(pcbd_pkg::MODE_NONE, $urandom, 6'($urandom),
                                16'($urandom), 8'($urandom), 1'($urandom),
                                4'($urandom));
                1: load_entry($urandom, 6'($urandom_range(1, 4)), 16'($urandom));
                default: send_byte(8'($urandom), $urandom_range(0, 5) == 0,
                                   4'($urandom));
            endcase
            items++;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_symbols.size() == 0) begin
            $display("PASS prefix_code_bitstream_decoder");
        end else begin
            $display("FAIL prefix_code_bitstream_decoder");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pcbd_pkg.sv
hdl/pcbd_cell.sv
hdl/prefix_code_bitstream_decoder.sv
verif/prefix_code_bitstream_decoder_tb.sv
